[src/rom_word_decrypt_dict_decompress_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ROM word decrypt and dictionary decompress block
// Shared property wrappers with clock, reset and message arguments.
// ----------------------------------------------------------------------------
`ifndef ROM_WORD_DECRYPT_DICT_DECOMPRESS_ASSERT_SVH
`define ROM_WORD_DECRYPT_DICT_DECOMPRESS_ASSERT_SVH

// Same-cycle implication, off during reset
`define RWDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define RWDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/rwdd_pkg.sv]
// ----------------------------------------------------------------------------
// rwdd_pkg
// Constants, state type and control/status bundles of the decompressor.
// ----------------------------------------------------------------------------
package rwdd_pkg;

  // Stream format
  localparam int unsigned WordBits   = 32;
  localparam int unsigned BufBits    = 64;
  localparam int unsigned DictSize   = 111;
  localparam int unsigned MidBase    = 16;
  localparam int unsigned LongBase   = 48;
  localparam int unsigned MaxCarry   = 11;
  localparam int unsigned MaxBufFill = MaxCarry + WordBits;
  localparam int unsigned CntW       = 7;
  localparam int unsigned IdxW       = 7;
  localparam int unsigned ByteW      = 8;

  // Two-bit code prefixes
  localparam logic [1:0] PfxShort = 2'b00;
  localparam logic [1:0] PfxSmall = 2'b01;
  localparam logic [1:0] PfxMid   = 2'b10;
  localparam logic [1:0] PfxLong  = 2'b11;

  // Escape value of the long code that ends the stream
  localparam logic [5:0] LongEnd = 6'h3f;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_DECODE
  } rwdd_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic fill_step;
    logic decode_step;
  } rwdd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_done;
    logic fill_avail;
    logic code_ok;
    logic ended;
    logic stall;
  } rwdd_status_t;

endpackage

[src/rwdd_if.sv]
// ----------------------------------------------------------------------------
// rwdd_if
// Valid/ready channels for ROM words in and decoded results out.
// ----------------------------------------------------------------------------
interface rwdd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] rom_word;
  logic        start_req;

  modport source (output valid, output rom_word, output start_req, input ready);
  modport sink   (input valid, input rom_word, input start_req, output ready);
endinterface

interface rwdd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       stream_end;
  logic       last;

  modport source (output valid, output out_byte, output byte_valid,
                  output stream_end, output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input stream_end, input last, output ready);
endinterface

[src/rwdd_ram.sv]
// ----------------------------------------------------------------------------
// rwdd_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rwdd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 111,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, hold data while not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/rwdd_ctrl.sv]
// ----------------------------------------------------------------------------
// rwdd_ctrl
// Sequencer: take a word, fill the dictionary, then decode one code a cycle while the output does not stall.
// ----------------------------------------------------------------------------
module rwdd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rwdd_pkg::rwdd_status_t status_i,
  output rwdd_pkg::rwdd_cmd_t    cmd_o
);

  rwdd_pkg::rwdd_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rwdd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rwdd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = rwdd_pkg::ST_FILL;
        end
      end
      rwdd_pkg::ST_FILL: begin
        if (status_i.ended) begin
          state_d = rwdd_pkg::ST_IDLE;
        end else if (status_i.fill_done) begin
          state_d = rwdd_pkg::ST_DECODE;
        end else if (!status_i.fill_avail) begin
          state_d = rwdd_pkg::ST_IDLE;
        end
      end
      rwdd_pkg::ST_DECODE: begin
        if (!status_i.stall && !status_i.code_ok) begin
          state_d = rwdd_pkg::ST_IDLE;
        end
      end
      default: state_d = rwdd_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o.load        = 1'b0;
    cmd_o.fill_step   = 1'b0;
    cmd_o.decode_step = 1'b0;
    unique case (state_q)
      rwdd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rwdd_pkg::ST_FILL: begin
        cmd_o.fill_step = !status_i.ended && !status_i.fill_done && status_i.fill_avail;
      end
      rwdd_pkg::ST_DECODE: begin
        cmd_o.decode_step = !status_i.stall && status_i.code_ok;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[src/rwdd_dp.sv]
// ----------------------------------------------------------------------------
// rwdd_dp
// Datapath: word unscramble, bit buffer, dictionary RAM, code decode,
// delta step and output register.
// ----------------------------------------------------------------------------
`include "rom_word_decrypt_dict_decompress_assert.svh"

module rwdd_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [31:0]            cfg_wdata_i,
  input  logic [31:0]            rom_word_i,
  input  logic                   start_req_i,
  input  rwdd_pkg::rwdd_cmd_t     cmd_i,
  output rwdd_pkg::rwdd_status_t  status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   byte_valid_o,
  output logic                   stream_end_o,
  output logic                   last_o
);

  localparam int unsigned BufW = rwdd_pkg::BufBits;
  localparam int unsigned WrdW = rwdd_pkg::WordBits;
  localparam int unsigned CntW = rwdd_pkg::CntW;
  localparam int unsigned IdxW = rwdd_pkg::IdxW;
  localparam int unsigned ByteW = rwdd_pkg::ByteW;

  logic [WrdW-1:0]  key_q;
  logic [BufW-1:0]  bits_q, bits_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  fill_cnt_q, fill_cnt_d;
  logic             ended_q, ended_d;
  logic             delta_en_q;

  logic [WrdW-1:0]  mixed;
  logic [BufW-1:0]  base_bits;
  logic [CntW-1:0]  base_cnt;
  logic             base_ended;
  logic             fill_done;

  logic [11:0]      peek;
  logic [3:0]       code_len;
  logic [IdxW-1:0]  code_idx;
  logic             code_lit;
  logic             code_end;
  logic             code_ok;

  logic             b_valid_q;
  logic             b_lit_q;
  logic             b_end_q;
  logic [ByteW-1:0] b_litval_q;
  logic [ByteW-1:0] ram_rdata;

  logic [ByteW-1:0] prior0_q, prior1_q;
  logic [1:0]       hist_q;
  logic [ByteW-1:0] value;
  logic [ByteW-1:0] result;
  logic             advance;
  logic             emit;

  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_bvalid_q;
  logic             out_end_q;
  logic             out_last_q;

  // Key register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q <= cfg_wdata_i;
    end
  end

  // Unscramble: byte mix, then key
  assign mixed = key_q ^ {rom_word_i[15:8] ^ rom_word_i[31:24],
                          rom_word_i[7:0] ^ rom_word_i[23:16],
                          rom_word_i[15:8], rom_word_i[7:0]};

  assign fill_done = (fill_cnt_q == IdxW'(rwdd_pkg::DictSize));

  // Decode the code at the head of the buffer
  assign peek = bits_q[BufW-1 -: 12];
  always_comb begin
    code_len = 4'd4;
    code_idx = '0;
    code_lit = 1'b0;
    code_end = 1'b0;
    case (peek[11:10])
      rwdd_pkg::PfxShort: begin
        if (peek[9:8] != 2'b00) begin
          code_len = 4'd4;
          code_idx = IdxW'(peek[9:8]);
        end else begin
          code_len = 4'd12;
          code_lit = 1'b1;
        end
      end
      rwdd_pkg::PfxSmall: begin
        if (!peek[9]) begin
          code_len = 4'd5;
          code_idx = IdxW'(4) + IdxW'(peek[8:7]);
        end else begin
          code_len = 4'd6;
          code_idx = IdxW'(8) + IdxW'(peek[8:6]);
        end
      end
      rwdd_pkg::PfxMid: begin
        code_len = 4'd7;
        code_idx = IdxW'(rwdd_pkg::MidBase) + IdxW'(peek[9:5]);
      end
      default: begin
        code_len = 4'd8;
        code_idx = IdxW'(rwdd_pkg::LongBase) + IdxW'(peek[9:4]);
        code_end = (peek[9:4] == rwdd_pkg::LongEnd);
      end
    endcase
  end

  assign code_ok = !ended_q && (cnt_q >= CntW'(code_len));

  // Bit buffer, fill count and end flag
  always_comb begin
    base_bits  = start_req_i ? '0 : bits_q;
    base_cnt   = start_req_i ? '0 : cnt_q;
    base_ended = start_req_i ? 1'b0 : ended_q;
    bits_d     = bits_q;
    cnt_d      = cnt_q;
    fill_cnt_d = fill_cnt_q;
    ended_d    = ended_q;
    if (cmd_i.load) begin
      bits_d     = base_bits;
      cnt_d      = base_cnt;
      ended_d    = base_ended;
      fill_cnt_d = start_req_i ? '0 : fill_cnt_q;
      if (!base_ended) begin
        bits_d = base_bits | ({mixed, {WrdW{1'b0}}} >> base_cnt);
        cnt_d  = base_cnt + CntW'(WrdW);
      end
    end else if (cmd_i.fill_step) begin
      bits_d     = bits_q << ByteW;
      cnt_d      = cnt_q - CntW'(ByteW);
      fill_cnt_d = fill_cnt_q + IdxW'(1);
    end else if (cmd_i.decode_step) begin
      if (code_end) begin
        bits_d  = '0;
        cnt_d   = '0;
        ended_d = 1'b1;
      end else begin
        bits_d = bits_q << code_len;
        cnt_d  = cnt_q - CntW'(code_len);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q     <= '0;
      cnt_q      <= '0;
      fill_cnt_q <= '0;
      ended_q    <= 1'b0;
      delta_en_q <= 1'b0;
    end else begin
      bits_q     <= bits_d;
      cnt_q      <= cnt_d;
      fill_cnt_q <= fill_cnt_d;
      ended_q    <= ended_d;
      if (cmd_i.fill_step && fill_cnt_q == '0) begin
        delta_en_q <= bits_q[BufW-2];
      end
    end
  end

  // Dictionary
  rwdd_ram #(
    .Width (ByteW),
    .Depth (rwdd_pkg::DictSize)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fill_step),
    .waddr_i (fill_cnt_q),
    .wdata_i (bits_q[BufW-1 -: ByteW]),
    .re_i    (cmd_i.decode_step && !code_end),
    .raddr_i (code_idx),
    .rdata_o (ram_rdata)
  );

  // Lookup stage, filled by each decoded code
  assign advance = !out_valid_q || out_ready_i;
  assign emit    = advance && b_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (advance) begin
      b_valid_q <= cmd_i.decode_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode_step) begin
      b_lit_q    <= code_lit;
      b_end_q    <= code_end;
      b_litval_q <= peek[ByteW-1:0];
    end
  end

  // Delta step against the byte two places back
  assign value  = b_lit_q ? b_litval_q : ram_rdata;
  assign result = (delta_en_q && hist_q == 2'd2) ? (prior0_q - value) : value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior0_q <= '0;
      prior1_q <= '0;
      hist_q   <= '0;
    end else if (cmd_i.load && start_req_i) begin
      prior0_q <= '0;
      prior1_q <= '0;
      hist_q   <= '0;
    end else if (emit && !b_end_q) begin
      prior0_q <= prior1_q;
      prior1_q <= result;
      if (hist_q != 2'd2) begin
        hist_q <= hist_q + 2'd1;
      end
    end
  end

  // Output register; last when no further code follows in this word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q   <= b_end_q ? '0 : result;
      out_bvalid_q <= !b_end_q;
      out_end_q    <= b_end_q;
      out_last_q   <= !cmd_i.decode_step;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = out_bvalid_q;
  assign stream_end_o = out_end_q;
  assign last_o       = out_last_q;

  assign status_o.fill_done  = fill_done;
  assign status_o.fill_avail = (cnt_q >= CntW'(ByteW));
  assign status_o.code_ok    = code_ok;
  assign status_o.ended      = ended_q;
  assign status_o.stall      = !advance;

  // Checks
  `RWDD_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(rwdd_pkg::MaxBufFill), "bit count beyond carry plus one word")
  `RWDD_ASSERT_IMP(a_ended_empty, clk_i, rst_ni, ended_q, cnt_q == '0 && bits_q == '0, "bits left after end code")
  `RWDD_ASSERT_IMP(a_decode_filled, clk_i, rst_ni, cmd_i.decode_step, fill_done, "decode before dictionary is full")
  `RWDD_ASSERT_IMP(a_fill_legal, clk_i, rst_ni, cmd_i.fill_step, !fill_done && cnt_q >= CntW'(ByteW), "dictionary write without a full byte")
  `RWDD_ASSERT_NXT(a_end_stops, clk_i, rst_ni, cmd_i.decode_step && code_end, !cmd_i.decode_step, "decode continued past end code")

endmodule

[src/rom_word_decrypt_dict_decompress.sv]
// ----------------------------------------------------------------------------
// rom_word_decrypt_dict_decompress
// Cartridge ROM word unscrambler and dictionary decompressor, top level.
// ----------------------------------------------------------------------------
// A word is taken when in_i.ready is high, which happens only while the
// block is between words. Once the dictionary is loaded, each word passes
// through the fill stage, then the decoder retires one prefix code per cycle
// while the output register can take it, then the block returns to idle.
// While the dictionary loads, the fill stage instead writes each whole byte
// of the word (up to four) into the dictionary before it leaves. The decoder
// reads through the single read port of the dictionary RAM. Each result
// waits in an output register; while out_o.ready is low and that register
// is full, the decoder holds. The first 888 bits after reset or start_req
// load the dictionary and give no results. The user must write the key
// through cfg_we_i/cfg_wdata_i only while no word is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module rom_word_decrypt_dict_decompress (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  rwdd_in_if.sink     in_i,
  rwdd_out_if.source  out_o
);

  rwdd_pkg::rwdd_cmd_t    cmd;
  rwdd_pkg::rwdd_status_t status;

  rwdd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rwdd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rom_word_i   (in_i.rom_word),
    .start_req_i  (in_i.start_req),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_byte_o   (out_o.out_byte),
    .byte_valid_o (out_o.byte_valid),
    .stream_end_o (out_o.stream_end),
    .last_o       (out_o.last)
  );

endmodule

[tb/sv/rom_word_decrypt_dict_decompress_tb.sv]
// ----------------------------------------------------------------------------
// rom_word_decrypt_dict_decompress_tb
// Drives ROM words through the valid/ready input channel and checks every
// decoded word on the output channel against a bit-exact decoder kept here.
// Streams are assembled bit by bit: a 111-byte dictionary, prefix codes and
// the end code, then scrambled for the current key. A short directed table
// runs first, then random streams, broken streams and noise under varied
// keys, sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module rom_word_decrypt_dict_decompress_tb;

  localparam int MaxCodes    = 11;
  localparam int TargetWords = 280;
  localparam int HoldOff     = 40;
  localparam int DrainCycles = 40;
  localparam int StallLimit  = 2000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       stream_end;
    logic       last;
  } dec_result_t;

  typedef enum logic [2:0] {
    DIR_RAW,
    DIR_START,
    DIR_DICT,
    DIR_CODE,
    DIR_LIT,
    DIR_END,
    DIR_PAD
  } dir_op_e;

  typedef struct packed {
    dir_op_e op;
    int      val;
    int      want;
  } dir_row_t;

  // Directed rows; want is the decoded byte where it is obvious, else -1.
  // Stream one uses an identity dictionary, so a code yields its own index.
  localparam dir_row_t DirRows [28] = '{
    '{DIR_RAW,   32'h0000_0000, -1},
    '{DIR_RAW,   32'hffff_ffff, -1},
    '{DIR_START, 0,   -1},
    '{DIR_DICT,  0,   -1},
    '{DIR_CODE,  1,   1},
    '{DIR_CODE,  3,   3},
    '{DIR_LIT,   0,   0},
    '{DIR_LIT,   255, 255},
    '{DIR_CODE,  4,   4},
    '{DIR_CODE,  7,   7},
    '{DIR_CODE,  8,   8},
    '{DIR_CODE,  15,  15},
    '{DIR_CODE,  16,  16},
    '{DIR_CODE,  47,  47},
    '{DIR_CODE,  48,  48},
    '{DIR_CODE,  110, 110},
    '{DIR_END,   0,   -1},
    '{DIR_PAD,   0,   -1},
    '{DIR_RAW,   32'h5a5a_a5a5, -1},
    '{DIR_START, 0,   -1},
    '{DIR_DICT,  8'h40, -1},
    '{DIR_CODE,  100, -1},
    '{DIR_CODE,  2,   -1},
    '{DIR_LIT,   8'h80, -1},
    '{DIR_CODE,  60,  -1},
    '{DIR_CODE,  9,   -1},
    '{DIR_END,   0,   -1},
    '{DIR_PAD,   0,   -1}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  rwdd_in_if  in_if ();
  rwdd_out_if out_if ();

  rom_word_decrypt_dict_decompress dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Decoder state
  logic [31:0] xkey;
  logic [63:0] pend_bits;
  int          pend_cnt;
  logic [7:0]  dict_mem [rwdd_pkg::DictSize];
  int          dict_fill;
  logic [7:0]  back0, back1;
  int          back_cnt;
  bit          stream_done;
  bit          word_ignored;

  dec_result_t due_bytes [$];
  int          typed_vals [$];

  // Stream assembler state
  logic [63:0] enc_bits;
  int          enc_cnt;
  bit          start_pending;
  int          burst_left;
  bit          gaps_on;
  int          live_words;
  int          err_cnt;

  // --------------------------------------------------------------------------
  // Decoder
  // --------------------------------------------------------------------------
  function automatic logic [11:0] peek_top(int n);
    logic [63:0] t;
    t = pend_bits >> (pend_cnt - n);
    return t[11:0] & ((12'd1 << n) - 12'd1);
  endfunction

  function automatic void drop_top(int n);
    pend_cnt -= n;
    if (pend_cnt == 0) pend_bits = '0;
    else pend_bits &= ({64{1'b1}} >> (rwdd_pkg::BufBits - pend_cnt));
  endfunction

  function automatic void restart_stream();
    pend_bits   = '0;
    pend_cnt    = 0;
    dict_fill   = 0;
    back0       = '0;
    back1       = '0;
    back_cnt    = 0;
    stream_done = 1'b0;
  endfunction

  // Apply the optional two-back delta and advance the history
  function automatic logic [7:0] apply_delta(logic [7:0] v);
    logic [7:0] o;
    o = v;
    if (dict_mem[0][6] && back_cnt >= 2) o = back0 - v;
    back0 = back1;
    back1 = o;
    if (back_cnt < 2) back_cnt++;
    return o;
  endfunction

  function automatic void push_byte(logic [7:0] v);
    dec_result_t r;
    int          t;
    r = '{out_byte: apply_delta(v), byte_valid: 1'b1, stream_end: 1'b0, last: 1'b0};
    if (typed_vals.size() != 0) begin
      t = typed_vals.pop_front();
      if (t >= 0) r.out_byte = t[7:0];
    end
    due_bytes.push_back(r);
  endfunction

  function automatic void decode_word(logic [31:0] w, logic s);
    logic [31:0] mixed;
    logic [11:0] code;
    int          n;
    int          idx;
    bit          got;
    if (s) restart_stream();
    word_ignored = stream_done;
    if (stream_done) return;
    mixed = xkey ^ {w[15:8] ^ w[31:24], w[7:0] ^ w[23:16], w[15:8], w[7:0]};
    pend_bits = (pend_bits << rwdd_pkg::WordBits) | 64'(mixed);
    pend_cnt += rwdd_pkg::WordBits;

    // Load the dictionary first
    while (dict_fill < rwdd_pkg::DictSize && pend_cnt >= 8) begin
      dict_mem[dict_fill] = 8'(peek_top(8));
      drop_top(8);
      dict_fill++;
    end

    // Decode complete codes
    n = 0;
    while (dict_fill >= rwdd_pkg::DictSize && !stream_done && n < MaxCodes) begin
      got = 1'b0;
      if (pend_cnt < 2) break;
      code = peek_top(2);
      case (code[1:0])
        rwdd_pkg::PfxShort: begin
          if (pend_cnt >= 4) begin
            code = peek_top(4);
            if (code[1:0] != 2'd0) begin
              drop_top(4);
              push_byte(dict_mem[code[1:0]]);
              got = 1'b1;
            end else if (pend_cnt >= 12) begin
              code = peek_top(12);
              drop_top(12);
              push_byte(code[7:0]);
              got = 1'b1;
            end
          end
        end
        rwdd_pkg::PfxSmall: begin
          if (pend_cnt >= 3) begin
            code = peek_top(3);
            if (!code[0] && pend_cnt >= 5) begin
              code = peek_top(5);
              drop_top(5);
              push_byte(dict_mem[int'(code[1:0]) + 4]);
              got = 1'b1;
            end else if (code[0] && pend_cnt >= 6) begin
              code = peek_top(6);
              drop_top(6);
              push_byte(dict_mem[int'(code[2:0]) + 8]);
              got = 1'b1;
            end
          end
        end
        rwdd_pkg::PfxMid: begin
          if (pend_cnt >= 7) begin
            code = peek_top(7);
            drop_top(7);
            push_byte(dict_mem[int'(code[4:0]) + rwdd_pkg::MidBase]);
            got = 1'b1;
          end
        end
        default: begin
          if (pend_cnt >= 8) begin
            code = peek_top(8);
            drop_top(8);
            idx = int'(code[5:0]) + rwdd_pkg::LongBase;
            if (idx >= rwdd_pkg::DictSize) begin
              stream_done = 1'b1;
              pend_bits   = '0;
              pend_cnt    = 0;
              due_bytes.push_back('{out_byte: 8'h00, byte_valid: 1'b0,
                                    stream_end: 1'b1, last: 1'b0});
            end else begin
              push_byte(dict_mem[idx]);
            end
            got = 1'b1;
          end
        end
      endcase
      if (!got) break;
      n++;
    end
    if (n > 0) due_bytes[due_bytes.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [31:0] w, input logic s);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid     <= 1'b1;
    in_if.rom_word  <= w;
    in_if.start_req <= s;
    do @(posedge clk_i); while (!in_if.ready);
    decode_word(w, s);
    if (!word_ignored) live_words++;
  endtask

  // Undo the byte mixing and key so that the block sees value t
  function automatic logic [31:0] rom_word_for(logic [31:0] t);
    logic [31:0] m;
    m = t ^ xkey;
    return {m[31:24] ^ m[15:8], m[23:16] ^ m[7:0], m[15:8], m[7:0]};
  endfunction

  // Append bits MSB first; send a word as soon as 32 are gathered
  task automatic put_bits(input logic [11:0] val, input int len);
    logic [63:0] t;
    enc_bits = (enc_bits << len) | (64'(val) & ((64'd1 << len) - 64'd1));
    enc_cnt += len;
    if (enc_cnt >= rwdd_pkg::WordBits) begin
      t = enc_bits >> (enc_cnt - rwdd_pkg::WordBits);
      enc_cnt -= rwdd_pkg::WordBits;
      enc_bits = (enc_cnt == 0) ? '0 : enc_bits & ((64'd1 << enc_cnt) - 64'd1);
      send_word(rom_word_for(t[31:0]), start_pending);
      start_pending = 1'b0;
    end
  endtask

  // Index 0 is the literal escape; an index of DictSize or more ends the stream
  task automatic put_code(input int idx, input logic [7:0] lit);
    if (idx >= rwdd_pkg::DictSize)
      put_bits({4'b0, rwdd_pkg::PfxLong, rwdd_pkg::LongEnd}, 8);
    else if (idx == 0)
      put_bits({rwdd_pkg::PfxShort, 2'b00, lit}, 12);
    else if (idx < 4)
      put_bits({8'b0, rwdd_pkg::PfxShort, 2'(idx)}, 4);
    else if (idx < 8)
      put_bits({7'b0, rwdd_pkg::PfxSmall, 1'b0, 2'(idx - 4)}, 5);
    else if (idx < rwdd_pkg::MidBase)
      put_bits({6'b0, rwdd_pkg::PfxSmall, 1'b1, 3'(idx - 8)}, 6);
    else if (idx < rwdd_pkg::LongBase)
      put_bits({5'b0, rwdd_pkg::PfxMid, 5'(idx - rwdd_pkg::MidBase)}, 7);
    else
      put_bits({4'b0, rwdd_pkg::PfxLong, 6'(idx - rwdd_pkg::LongBase)}, 8);
  endtask

  task automatic pad_word();
    while (enc_cnt != 0)
      put_bits(12'($urandom_range(0, 255)),
               (rwdd_pkg::WordBits - enc_cnt) < 8 ? rwdd_pkg::WordBits - enc_cnt : 8);
  endtask

  // Write the key once the block has drained
  task automatic set_key(input logic [31:0] k);
    in_if.valid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk_i);
    repeat (HoldOff) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    xkey = k;
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_index();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom_range(0, 3);
      2:       return $urandom_range(4, 7);
      3:       return $urandom_range(8, rwdd_pkg::MidBase - 1);
      4, 5, 6: return $urandom_range(rwdd_pkg::MidBase, rwdd_pkg::LongBase - 1);
      default: return $urandom_range(rwdd_pkg::LongBase, rwdd_pkg::DictSize - 1);
    endcase
  endfunction

  // One stream with random content; some are cut short by the next start
  task automatic random_stream();
    int ncodes;
    gaps_on = ($urandom_range(0, 2) != 0);
    start_pending = 1'b1;
    for (int i = 0; i < rwdd_pkg::DictSize; i++) put_bits(12'($urandom_range(0, 255)), 8);
    ncodes = $urandom_range(8, 60);
    for (int i = 0; i < ncodes; i++) put_code(pick_index(), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) != 0) put_code(rwdd_pkg::DictSize, 8'h00);
    pad_word();
    // Trailing noise, sometimes with a restart that leads nowhere
    repeat ($urandom_range(0, 2)) send_word($urandom, 1'b0);
    if ($urandom_range(0, 3) == 0) begin
      send_word($urandom, 1'b1);
      repeat ($urandom_range(0, 3)) send_word($urandom, 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, receiver stalls, checking and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the output on one of four randomly chosen patterns: always ready, random, or one of two periodic ones
  initial begin
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        2:       out_if.ready <= (cyc % 7) >= 3;
        default: out_if.ready <= (cyc % 20) >= 8;
      endcase
      cyc++;
    end
  end

  // Compare each word taken from the output with the oldest expected one
  always @(posedge clk_i) begin
    dec_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_bytes.size() == 0) begin
        $error("unexpected word: out_byte %0h byte_valid %0b stream_end %0b last %0b",
               out_if.out_byte, out_if.byte_valid, out_if.stream_end, out_if.last);
        err_cnt++;
      end else begin
        want = due_bytes.pop_front();
        if (out_if.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_if.out_byte);
          err_cnt++;
        end
        if (out_if.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_if.byte_valid);
          err_cnt++;
        end
        if (out_if.stream_end !== want.stream_end) begin
          $error("stream_end: expected %0b, got %0b", want.stream_end, out_if.stream_end);
          err_cnt++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_if.last);
          err_cnt++;
        end
      end
    end
  end

  // End the run when no word moves on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("rom_word_decrypt_dict_decompress verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int sidx;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    in_if.valid     <= 1'b0;
    in_if.rom_word  <= '0;
    in_if.start_req <= 1'b0;
    xkey = '0;
    foreach (dict_mem[i]) dict_mem[i] = '0;
    restart_stream();
    enc_bits      = '0;
    enc_cnt       = 0;
    start_pending = 1'b0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    live_words    = 0;
    err_cnt       = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (DirRows[r]) begin
      case (DirRows[r].op)
        DIR_RAW:   send_word(DirRows[r].val, 1'b0);
        DIR_START: start_pending = 1'b1;
        DIR_DICT: begin
          for (int i = 0; i < rwdd_pkg::DictSize; i++)
            put_bits(i == 0 ? 12'(DirRows[r].val) : 12'(i), 8);
        end
        DIR_CODE: begin
          typed_vals.push_back(DirRows[r].want);
          put_code(DirRows[r].val, 8'h00);
        end
        DIR_LIT: begin
          typed_vals.push_back(DirRows[r].want);
          put_code(0, 8'(DirRows[r].val));
        end
        DIR_END:   put_code(rwdd_pkg::DictSize, 8'h00);
        default:   pad_word();
      endcase
    end

    // Random streams under changing keys, both extremes first
    sidx = 0;
    while (live_words < TargetWords) begin
      if (sidx == 0)                      set_key(32'hffff_ffff);
      else if (sidx == 1)                 set_key(32'h0000_0000);
      else if ($urandom_range(0, 1) == 0) set_key($urandom);
      random_stream();
      sidx++;
    end

    // Drain
    in_if.valid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("rom_word_decrypt_dict_decompress verification clean");
    end else begin
      $display("rom_word_decrypt_dict_decompress verification failed");
    end
    $finish;
  end

endmodule
